>>> rtl/core/tbcs_pkg.sv
// Shared package of the tiny byte CPU step unit: widths, command and opcode codes,
// and the structs that travel between the command buffer, the core and the top level.
// Depends on nothing.
package tbcs_pkg;

    localparam int MEM_WORDS_DEF = 256;
    localparam int BYTE_W        = 8;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 80;

    // Commands carried in the input tuser field.
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_READ    = 2'd1;
    localparam logic [1:0] CMD_EXEC    = 2'd2;
    localparam logic [1:0] CMD_RESTART = 2'd3;

    // Instruction opcodes.
    localparam logic [7:0] OP_LOAD  = 8'h01;
    localparam logic [7:0] OP_STORE = 8'h02;
    localparam logic [7:0] OP_ADD   = 8'h03;
    localparam logic [7:0] OP_SUB   = 8'h04;
    localparam logic [7:0] OP_MOV   = 8'h05;
    localparam logic [7:0] OP_CMP   = 8'h06;
    localparam logic [7:0] OP_JMP   = 8'h07;
    localparam logic [7:0] OP_JZ    = 8'h08;
    localparam logic [7:0] OP_JNZ   = 8'h09;
    localparam logic [7:0] OP_HALT  = 8'h0A;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] address;
        logic [7:0] write_data;
    } cmd_t;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic [7:0] reg0_value;
        logic [7:0] reg1_value;
        logic [7:0] reg2_value;
        logic [7:0] reg3_value;
        logic [7:0] pc_value;
        logic       zero_flag;
        logic       halted;
        logic [7:0] read_data;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
    } core_out_t;

endpackage

>>> rtl/core/tbcs_ram.sv
// Generic single-port synchronous RAM with a registered read, one access per cycle.
// Depends on nothing.
module tbcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

>>> rtl/core/tbcs_in_buf.sv
// One-entry command buffer on the input stream; it lets a transfer land while the
// core still works on the previous command. Depends on tbcs_pkg.
module tbcs_in_buf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tbcs_pkg::cmd_t in_cmd,
    output logic          cmd_valid,
    output tbcs_pkg::cmd_t cmd,
    input  logic          cmd_take
);
    import tbcs_pkg::*;

    logic full_reg;
    logic full_next;
    cmd_t cmd_reg;

    assign in_ready  = !full_reg || cmd_take;
    assign cmd_valid = full_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        full_next = full_reg;
        if (in_valid && in_ready)
        begin
            full_next = 1'b1;
        end
        else if (cmd_take)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= in_cmd;
        end
    end

endmodule

>>> rtl/core/tbcs_core.sv
// Sequencer and datapath of the CPU: register file, flags, program counter, per-byte
// valid bits and the memory access schedule. Depends on tbcs_pkg and tbcs_ram.
module tbcs_core #(
    parameter int MEM_WORDS = tbcs_pkg::MEM_WORDS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          start_address,
    input  logic                cmd_valid,
    input  tbcs_pkg::cmd_t      cmd,
    output logic                cmd_take,
    input  logic                out_free,
    output tbcs_pkg::core_out_t core_out
);
    import tbcs_pkg::*;

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_F1   = 3'd2;
    localparam logic [2:0] S_F2   = 3'd3;
    localparam logic [2:0] S_F3   = 3'd4;
    localparam logic [2:0] S_LD   = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]  st_reg, st_next;
    logic [7:0]  pc_reg, pc_next;
    logic        zf_reg, zf_next;
    logic        halt_reg, halt_next;
    logic [7:0]  gpr_reg [4];
    logic [7:0]  gpr_next [4];
    logic [7:0]  op_reg, op_next;
    logic [7:0]  a_reg, a_next;
    logic [7:0]  b_reg, b_next;
    logic [7:0]  rd_reg, rd_next;
    logic        vld_reg [MEM_WORDS];
    logic        rvld_reg;

    logic [AW-1:0] idx_tbl [256];
    logic          start;
    logic          emit;
    logic          ram_we;
    logic [7:0]    ram_addr8;
    logic [AW-1:0] ram_idx;
    logic [7:0]    ram_wdata;
    logic [7:0]    ram_rdata;
    logic [7:0]    rd_eff;
    logic [1:0]    ra;
    logic [1:0]    rb;
    logic [7:0]    reg_a;
    logic [7:0]    reg_b;

    // Byte address to memory index, folded modulo the memory depth.
    for (genvar g = 0; g < 256; g++)
    begin : g_idx
        assign idx_tbl[g] = AW'(g % MEM_WORDS);
    end

    assign ram_idx = idx_tbl[ram_addr8];

    tbcs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_idx),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // A byte never written since reset reads as zero.
    assign rd_eff = rvld_reg ? ram_rdata : 8'd0;

    assign emit     = (st_reg == S_DONE) && out_free;
    assign start    = cmd_valid && ((st_reg == S_IDLE) || emit);
    assign cmd_take = start;

    // In the last fetch cycle the live read data is operand b.
    assign ra    = a_reg[1:0];
    assign rb    = rd_eff[1:0];
    assign reg_a = gpr_reg[ra];
    assign reg_b = gpr_reg[rb];

    always_comb
    begin
        st_next   = st_reg;
        pc_next   = pc_reg;
        zf_next   = zf_reg;
        halt_next = halt_reg;
        gpr_next  = gpr_reg;
        op_next   = op_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        rd_next   = rd_reg;
        ram_we    = 1'b0;
        ram_addr8 = pc_reg;
        ram_wdata = 8'd0;

        unique case (st_reg)
            S_IDLE:
            begin
                st_next = S_IDLE;
            end
            S_RD:
            begin
                rd_next = rd_eff;
                st_next = S_DONE;
            end
            S_F1:
            begin
                op_next   = rd_eff;
                ram_addr8 = pc_reg + 8'd1;
                st_next   = S_F2;
            end
            S_F2:
            begin
                a_next    = rd_eff;
                ram_addr8 = pc_reg + 8'd2;
                st_next   = S_F3;
            end
            S_F3:
            begin
                b_next  = rd_eff;
                pc_next = pc_reg + 8'd3;
                st_next = S_DONE;
                case (op_reg)
                    OP_LOAD:
                    begin
                        ram_addr8 = rd_eff;
                        st_next   = S_LD;
                    end
                    OP_STORE:
                    begin
                        ram_we    = 1'b1;
                        ram_addr8 = rd_eff;
                        ram_wdata = reg_a;
                    end
                    OP_ADD:  gpr_next[ra] = reg_a + reg_b;
                    OP_SUB:  gpr_next[ra] = reg_a - reg_b;
                    OP_MOV:  gpr_next[ra] = rd_eff;
                    OP_CMP:  zf_next = (reg_a == reg_b);
                    OP_JMP:  pc_next = a_reg;
                    OP_JZ:
                    begin
                        if (zf_reg)
                        begin
                            pc_next = a_reg;
                        end
                    end
                    OP_JNZ:
                    begin
                        if (!zf_reg)
                        begin
                            pc_next = a_reg;
                        end
                    end
                    OP_HALT: halt_next = 1'b1;
                    default:
                    begin
                    end
                endcase
            end
            S_LD:
            begin
                gpr_next[ra] = rd_eff;
                st_next      = S_DONE;
            end
            S_DONE:
            begin
                st_next = emit ? S_IDLE : S_DONE;
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase

        // A new command starts from idle, or in the same cycle the previous result leaves.
        if (start)
        begin
            op_next = 8'd0;
            a_next  = 8'd0;
            b_next  = 8'd0;
            rd_next = 8'd0;
            unique case (cmd.command)
                CMD_WRITE:
                begin
                    ram_we    = 1'b1;
                    ram_addr8 = cmd.address;
                    ram_wdata = cmd.write_data;
                    st_next   = S_DONE;
                end
                CMD_READ:
                begin
                    ram_addr8 = cmd.address;
                    st_next   = S_RD;
                end
                CMD_EXEC:
                begin
                    ram_addr8 = pc_reg;
                    st_next   = halt_reg ? S_DONE : S_F1;
                end
                CMD_RESTART:
                begin
                    pc_next   = start_address;
                    halt_next = 1'b0;
                    st_next   = S_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            pc_reg   <= 8'd0;
            zf_reg   <= 1'b0;
            halt_reg <= 1'b0;
            rvld_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                gpr_reg[i] <= 8'd0;
            end
            for (int i = 0; i < MEM_WORDS; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else
        begin
            st_reg   <= st_next;
            pc_reg   <= pc_next;
            zf_reg   <= zf_next;
            halt_reg <= halt_next;
            gpr_reg  <= gpr_next;
            rvld_reg <= vld_reg[ram_idx];
            if (ram_we)
            begin
                vld_reg[ram_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        a_reg  <= a_next;
        b_reg  <= b_next;
        rd_reg <= rd_next;
    end

    assign core_out.emit           = emit;
    assign core_out.res.opcode     = op_reg;
    assign core_out.res.operand_a  = a_reg;
    assign core_out.res.operand_b  = b_reg;
    assign core_out.res.reg0_value = gpr_reg[0];
    assign core_out.res.reg1_value = gpr_reg[1];
    assign core_out.res.reg2_value = gpr_reg[2];
    assign core_out.res.reg3_value = gpr_reg[3];
    assign core_out.res.pc_value   = pc_reg;
    assign core_out.res.zero_flag  = zf_reg;
    assign core_out.res.halted     = halt_reg;
    assign core_out.res.read_data  = rd_reg;

endmodule

>>> rtl/core/tiny_byte_cpu_step_unit.sv
// Per command: a write, a restart or an execute while halted goes straight to its
// result; a read passes the read state, an instruction the fetch states, and LOAD the
// load state too. One memory port serves all accesses: three fetch reads per instruction
// and one data access for LOAD or STORE. The input buffer takes the next command while
// the core works. Reset clears memory contents (through per-byte valid bits), registers,
// flags, program counter and start address at once; no clearing pass.
module tiny_byte_cpu_step_unit #(
    parameter int MEM_WORDS = tbcs_pkg::MEM_WORDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration: start address loaded by the restart command.
    input  logic                                cfg_wr_en,
    input  logic [7:0]                          cfg_wr_data,
    // Input stream. tuser: command[1:0].
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [1:0]                          s_axis_tuser,
    // tdata: address[7:0], write_data[15:8].
    input  logic [tbcs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // Output stream.
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata: opcode[7:0], operand_a[15:8], operand_b[23:16], reg0_value[31:24],
    // reg1_value[39:32], reg2_value[47:40], reg3_value[55:48], pc_value[63:56],
    // zero_flag[64], halted[65], read_data[73:66], zero fill [79:74].
    output logic [tbcs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import tbcs_pkg::*;

    logic [7:0] start_address_reg;
    cmd_t      in_cmd;
    cmd_t      cmd;
    logic      cmd_valid;
    logic      cmd_take;
    logic      out_free;
    core_out_t core_out;
    logic      out_valid_reg;
    logic      out_valid_next;
    result_t   out_res_reg;

    // The user must write the start address only while the block is idle; the block does not enforce this.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_address_reg <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            start_address_reg <= cfg_wr_data;
        end
    end

    assign in_cmd.command    = s_axis_tuser;
    assign in_cmd.address    = s_axis_tdata[7:0];
    assign in_cmd.write_data = s_axis_tdata[15:8];

    // The input buffer takes a new transfer while the core still works on a command.
    tbcs_in_buf u_in_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_cmd    (in_cmd),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    tbcs_core #(
        .MEM_WORDS (MEM_WORDS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .start_address (start_address_reg),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_take      (cmd_take),
        .out_free      (out_free),
        .core_out      (core_out)
    );

    // The output register frees up in the same cycle its result is taken, so the core
    // can hand over the next result without a bubble.
    assign out_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (core_out.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_out.emit)
        begin
            out_res_reg <= core_out.res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0,
                            out_res_reg.read_data,
                            out_res_reg.halted,
                            out_res_reg.zero_flag,
                            out_res_reg.pc_value,
                            out_res_reg.reg3_value,
                            out_res_reg.reg2_value,
                            out_res_reg.reg1_value,
                            out_res_reg.reg0_value,
                            out_res_reg.operand_b,
                            out_res_reg.operand_a,
                            out_res_reg.opcode};

endmodule

>>> rtl/core/tbcs_checker.sv
// Port-level checker of the tiny byte CPU step unit and its bind to the top level.
// Depends on tbcs_pkg and tiny_byte_cpu_step_unit.
module tbcs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [tbcs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import tbcs_pkg::*;

    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xfer && !out_xfer)
        begin
            pend_next = pend_reg + 3'd1;
        end
        else if (out_xfer && !in_xfer)
        begin
            pend_next = pend_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 3'd0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A result transfer always answers an earlier command transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (pend_reg != 3'd0))
        else $error("result offered with no command outstanding");

    // Buffer, core and output register hold at most three commands.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd3)
        else $error("too many commands outstanding");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // An executed halt leaves the machine halted.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[7:0] == OP_HALT) |-> m_axis_tdata[65])
        else $error("halt executed but halted flag clear");

    // An executed jump lands on its first operand.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[7:0] == OP_JMP) |->
            (m_axis_tdata[63:56] == m_axis_tdata[15:8]))
        else $error("jump did not load program counter");

endmodule

bind tiny_byte_cpu_step_unit tbcs_checker u_tbcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/tiny_byte_cpu_step_checker.sv
// Checker for the tiny byte CPU step unit: watches the command and result streams and
// the start address port, keeps its own copy of the machine state and compares results.
// Depends on tbcs_pkg for the command and opcode codes and the result struct.
module tiny_byte_cpu_step_checker #(
    parameter int MEM_WORDS = tbcs_pkg::MEM_WORDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [7:0]                          cfg_wr_data,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [1:0]                          s_axis_tuser,
    input  logic [tbcs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [tbcs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    output int                                  error_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tbcs_pkg::*;

    logic [7:0] mem_image [MEM_WORDS];
    logic [7:0] cpu_regs [4];
    logic [7:0] cpu_pc;
    logic [7:0] restart_pc;
    logic       cpu_zero;
    logic       cpu_halted;

    result_t    expected_states [$];

    function automatic int mem_slot(logic [7:0] addr);
        return int'(addr) % MEM_WORDS;
    endfunction

    // Applies one command to the shadow machine and returns the state it reports.
    function automatic result_t step_cpu(logic [1:0] cmd, logic [7:0] addr,
                                         logic [7:0] wdata);
        result_t    res;
        logic [7:0] op;
        logic [7:0] opa;
        logic [7:0] opb;
        logic [1:0] ra;
        logic [1:0] rb;
        res = '0;
        op  = '0;
        opa = '0;
        opb = '0;
        case (cmd)
            CMD_WRITE: mem_image[mem_slot(addr)] = wdata;
            CMD_READ:  res.read_data = mem_image[mem_slot(addr)];
            CMD_EXEC:
            begin
                if (!cpu_halted)
                begin
                    op     = mem_image[mem_slot(cpu_pc)];
                    opa    = mem_image[mem_slot(cpu_pc + 8'd1)];
                    opb    = mem_image[mem_slot(cpu_pc + 8'd2)];
                    cpu_pc = cpu_pc + 8'd3;
                    ra     = opa[1:0];
                    rb     = opb[1:0];
                    case (op)
                        OP_LOAD:  cpu_regs[ra] = mem_image[mem_slot(opb)];
                        OP_STORE: mem_image[mem_slot(opb)] = cpu_regs[ra];
                        OP_ADD:   cpu_regs[ra] = cpu_regs[ra] + cpu_regs[rb];
                        OP_SUB:   cpu_regs[ra] = cpu_regs[ra] - cpu_regs[rb];
                        OP_MOV:   cpu_regs[ra] = opb;
                        OP_CMP:   cpu_zero = (cpu_regs[ra] == cpu_regs[rb]);
                        OP_JMP:   cpu_pc = opa;
                        OP_JZ:    if (cpu_zero) cpu_pc = opa;
                        OP_JNZ:   if (!cpu_zero) cpu_pc = opa;
                        OP_HALT:  cpu_halted = 1'b1;
                        default:  ;
                    endcase
                end
            end
            default:
            begin
                cpu_pc     = restart_pc;
                cpu_halted = 1'b0;
            end
        endcase
        res.opcode     = op;
        res.operand_a  = opa;
        res.operand_b  = opb;
        res.reg0_value = cpu_regs[0];
        res.reg1_value = cpu_regs[1];
        res.reg2_value = cpu_regs[2];
        res.reg3_value = cpu_regs[3];
        res.pc_value   = cpu_pc;
        res.zero_flag  = cpu_zero;
        res.halted     = cpu_halted;
        return res;
    endfunction

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MEM_WORDS; i++)
                mem_image[i] = '0;
            for (int i = 0; i < 4; i++)
                cpu_regs[i] = '0;
            cpu_pc      = '0;
            restart_pc  = '0;
            cpu_zero    = 1'b0;
            cpu_halted  = 1'b0;
            expected_states.delete();
            error_count = 0;
            pending     = 0;
        end
        else
        begin
            if (cfg_wr_en)
                restart_pc = cfg_wr_data;
            // A result can never leave in the same cycle its command arrives, so the
            // result side is handled before the new command is pushed.
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_states.size() == 0)
                begin
                    $error("result transfer with no command outstanding: %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_states.pop_front();
                    check_field("opcode",     want.opcode,     m_axis_tdata[7:0]);
                    check_field("operand_a",  want.operand_a,  m_axis_tdata[15:8]);
                    check_field("operand_b",  want.operand_b,  m_axis_tdata[23:16]);
                    check_field("reg0_value", want.reg0_value, m_axis_tdata[31:24]);
                    check_field("reg1_value", want.reg1_value, m_axis_tdata[39:32]);
                    check_field("reg2_value", want.reg2_value, m_axis_tdata[47:40]);
                    check_field("reg3_value", want.reg3_value, m_axis_tdata[55:48]);
                    check_field("pc_value",   want.pc_value,   m_axis_tdata[63:56]);
                    check_field("zero_flag",  8'(want.zero_flag), 8'(m_axis_tdata[64]));
                    check_field("halted",     8'(want.halted),    8'(m_axis_tdata[65]));
                    check_field("read_data",  want.read_data,  m_axis_tdata[73:66]);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_states.push_back(step_cpu(s_axis_tuser, s_axis_tdata[7:0],
                                                   s_axis_tdata[15:8]));
            pending = expected_states.size();
        end
    end

endmodule

>>> tb/sv/tb_tiny_byte_cpu_step_unit.sv
// Top of the tiny byte CPU step unit testbench: clock, reset, command stimulus, result
// back-pressure and the final verdict. Depends on tbcs_pkg, the unit itself and
// tiny_byte_cpu_step_checker, which does all prediction and comparison.
module tb_tiny_byte_cpu_step_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import tbcs_pkg::*;

    // Rough number of commands to send before the run winds down.
    localparam int CMD_TARGET      = 1300;
    // The limit leaves a wide margin over the slowest correct run.
    localparam int CYCLE_LIMIT     = 300000;
    // Length of the one long result-side hold-off that fills the unit up.
    localparam int HOLD_OFF_CYCLES = 150;
    // The session during which the long hold-off happens.
    localparam int PRESSURE_SESSION = 12;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_wr_en;
    logic [7:0]                 cfg_wr_data;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [1:0]                 s_axis_tuser;
    logic [IN_TDATA_W-1:0]      s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;

    int                         error_count;
    int                         pending;

    // Percent chance, per command, that the command side pauses before offering
    // it, and, per falling edge outside a stall, that the result side stalls.
    int                         src_gap_pct;
    int                         snk_stall_pct;
    // Set by the stimulus to ask the result side for one long hold-off.
    int                         hold_request;
    int                         cmds_sent;
    int                         cycle_count = 0;
    // Mirror of the start address register, so programs can be placed there.
    logic [7:0]                 start_addr;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tiny_byte_cpu_step_unit #(
        .MEM_WORDS      (MEM_WORDS_DEF)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

    tiny_byte_cpu_step_checker #(
        .MEM_WORDS      (MEM_WORDS_DEF)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tuser   (s_axis_tuser),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .error_count    (error_count),
        .pending        (pending)
    );

    // Watchdog. A hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_tiny_byte_cpu_step_unit: done, errors");
            $finish;
        end
    end

    // Result side. Ready changes only at falling edges. Short stalls come at random; a
    // hold-off request drops ready for a long, counted stretch while the command side
    // keeps going, so the unit backs up and stops accepting.
    initial
    begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                stall = hold_request;
                hold_request = 0;
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (snk_stall_pct > 0 && $urandom_range(99) < snk_stall_pct)
            begin
                stall = $urandom_range(1, 3);
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offers one command at a falling edge, possibly after a short pause, and returns
    // at the rising edge where the transfer happens. Valid is left high, so the
    // caller must call this or settle right away at the next falling edge.
    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] addr,
                            input logic [7:0] wdata);
        int gap;
        @(negedge clk);
        if (src_gap_pct > 0 && $urandom_range(99) < src_gap_pct)
        begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {wdata, addr};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        cmds_sent++;
    endtask

    // Puts one three-byte instruction into memory; the byte addresses wrap at 256.
    task automatic write_instr(input logic [7:0] at, input logic [7:0] op,
                               input logic [7:0] opa, input logic [7:0] opb);
        send_cmd(CMD_WRITE, at, op);
        send_cmd(CMD_WRITE, at + 8'd1, opa);
        send_cmd(CMD_WRITE, at + 8'd2, opb);
    endtask

    // Stops offering commands and waits until every result has come out. Every
    // command yields a result, so an empty queue means the unit is idle; a few
    // more cycles are allowed on top for good measure.
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Writes the start address while the unit is idle.
    task automatic set_start(input logic [7:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        start_addr  = value;
    endtask

    // Writes a short random program at the start address, restarts there and
    // steps through it. Opcodes are mostly valid, with some halts and some
    // arbitrary bytes; jump targets mostly land on instructions of the program so
    // that loops and branches actually run. A few reads and writes are mixed in.
    task automatic program_session(input int n_instr);
        logic [7:0] at;
        logic [7:0] op;
        logic [7:0] opa;
        logic [7:0] opb;
        int         pick;
        int         steps;
        for (int i = 0; i < n_instr; i++)
        begin
            at   = start_addr + 8'(3 * i);
            pick = $urandom_range(99);
            if (pick < 6)
                op = 8'($urandom_range(255));
            else if (pick < 14)
                op = OP_HALT;
            else
                op = 8'($urandom_range(OP_JNZ, OP_LOAD));
            opa = 8'($urandom_range(255));
            opb = 8'($urandom_range(255));
            if (op inside {OP_JMP, OP_JZ, OP_JNZ} && $urandom_range(9) < 8)
                opa = start_addr + 8'(3 * $urandom_range(n_instr - 1));
            // Comparing a register with itself forces the zero flag on now and then.
            if (op == OP_CMP && $urandom_range(2) == 0)
                opb[1:0] = opa[1:0];
            write_instr(at, op, opa, opb);
        end
        send_cmd(CMD_RESTART, 8'($urandom_range(255)), 8'($urandom_range(255)));
        steps = n_instr + $urandom_range(n_instr + 2);
        repeat (steps)
        begin
            if ($urandom_range(9) == 0)
                send_cmd(2'($urandom_range(CMD_READ, CMD_WRITE)), 8'($urandom_range(255)),
                         8'($urandom_range(255)));
            send_cmd(CMD_EXEC, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    initial
    begin : stimulus
        int session;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = '0;
        s_axis_tdata  = '0;
        src_gap_pct   = 0;
        snk_stall_pct = 0;
        hold_request  = 0;
        cmds_sent     = 0;
        start_addr    = '0;
        session       = 0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The start address sits near the top of memory so that the first
        // instruction fetched after the restart wraps from address 255 back to 0.
        set_start(8'hFE);
        // Memory comes out of reset cleared.
        send_cmd(CMD_READ, 8'h00, 8'hFF);
        // Zero is not an opcode: the fetch still moves the program counter on.
        send_cmd(CMD_EXEC, 8'hFF, 8'h00);
        // MOV into register 3, named through an operand with its upper bits set.
        write_instr(8'hFE, OP_MOV, 8'hFF, 8'hFF);
        send_cmd(CMD_RESTART, 8'h00, 8'h00);
        send_cmd(CMD_EXEC, 8'h00, 8'h00);
        // 0xFF + 0xFF wraps to 0xFE.
        write_instr(8'h01, OP_ADD, 8'h03, 8'h07);
        send_cmd(CMD_EXEC, 8'h00, 8'h00);
        // 0 - 0xFE wraps to 0x02.
        write_instr(8'h04, OP_SUB, 8'hFC, 8'hFB);
        send_cmd(CMD_EXEC, 8'h00, 8'h00);
        write_instr(8'h07, OP_STORE, 8'h00, 8'h80);
        send_cmd(CMD_EXEC, 8'h00, 8'h00);
        send_cmd(CMD_READ, 8'h80, 8'h00);
        write_instr(8'h0A, OP_HALT, 8'h00, 8'h00);
        send_cmd(CMD_EXEC, 8'h00, 8'h00);
        // Once halted, a step reports zero opcode and operands and changes nothing, while
        // memory writes and reads still go through.
        send_cmd(CMD_EXEC, 8'h00, 8'h00);
        send_cmd(CMD_WRITE, 8'h40, 8'h3C);
        send_cmd(CMD_READ, 8'h40, 8'h00);

        // Random part: mostly program sessions, some pure noise. Pause and stall
        // rates change per session, including sessions with none at all, and the
        // last stretch of the run is free of both.
        while (cmds_sent < CMD_TARGET)
        begin
            if (cmds_sent > CMD_TARGET * 85 / 100)
            begin
                src_gap_pct   = 0;
                snk_stall_pct = 0;
            end
            else
            begin
                src_gap_pct   = 20 * $urandom_range(2);
                snk_stall_pct = 20 * $urandom_range(2);
            end

            // Start address changes happen only between sessions, with the unit idle.
            if ($urandom_range(9) < 4)
            begin
                case ($urandom_range(3))
                    0:       set_start(8'h00);
                    1:       set_start(8'hFF);
                    2:       set_start(8'hFD);
                    default: set_start(8'($urandom_range(255)));
                endcase
            end

            if (session == PRESSURE_SESSION)
            begin
                // Commands keep coming with no pauses while results are held back.
                src_gap_pct  = 0;
                hold_request = HOLD_OFF_CYCLES;
                program_session(8);
            end
            else if ($urandom_range(9) < 2)
            begin
                repeat ($urandom_range(8, 24))
                    send_cmd(2'($urandom_range(CMD_RESTART, CMD_WRITE)),
                             8'($urandom_range(255)), 8'($urandom_range(255)));
            end
            else
            begin
                program_session($urandom_range(2, 8));
            end
            session++;
        end

        // Drain, then allow a few cycles more for any stray result to show up.
        settle();
        repeat (12) @(negedge clk);
        if (error_count == 0)
            $display("tb_tiny_byte_cpu_step_unit: done, clean");
        else
            $display("tb_tiny_byte_cpu_step_unit: done, errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tbcs_pkg.sv
rtl/core/tbcs_ram.sv
rtl/core/tbcs_in_buf.sv
rtl/core/tbcs_core.sv
rtl/core/tiny_byte_cpu_step_unit.sv
rtl/core/tbcs_checker.sv
tb/sv/tiny_byte_cpu_step_checker.sv
tb/sv/tb_tiny_byte_cpu_step_unit.sv
